// ===== rtl/twspi_pkg.sv =====
package twspi_pkg;

  // widths fixed by the item fields
  localparam int unsigned CmdW       = 2;
  localparam int unsigned RegAddrW   = 7;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ReadLenW   = 5;
  localparam int unsigned HalfW      = 8;
  localparam int unsigned BitIdxW    = 3;

  // default burst limit
  localparam int unsigned MaxReadBytesDefault = 16;

  // reset value of the half period register
  localparam logic [HalfW-1:0] HalfPeriodReset = 8'd1;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CmdTick  = 2'd0,
    CmdWrite = 2'd1,
    CmdRead  = 2'd2
  } cmd_e;

  // frame sequencer phases
  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhStartHi = 4'd1,
    PhStartLo = 4'd2,
    PhTxLow   = 4'd3,
    PhTxHigh  = 4'd4,
    PhRxLow   = 4'd5,
    PhRxHigh  = 4'd6,
    PhFinClk  = 4'd7,
    PhFinCs   = 4'd8
  } phase_e;

  // one result of the sequencer
  typedef struct packed {
    logic             chip_select_n;
    logic             serial_clock;
    logic             data_out;
    logic             data_drive;
    logic [ByteW-1:0] read_byte;
    logic             byte_valid;
    logic             last_byte;
    logic             busy_res;
  } result_t;

endpackage

// ===== rtl/twspi_seq.sv =====
module twspi_seq #(
  parameter int unsigned MaxReadBytes = twspi_pkg::MaxReadBytesDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [twspi_pkg::CmdW-1:0]       command_i,
  input  logic [twspi_pkg::RegAddrW-1:0]   reg_addr_i,
  input  logic [twspi_pkg::ByteW-1:0]      write_value_i,
  input  logic [twspi_pkg::ReadLenW-1:0]   read_length_i,
  input  logic                             sdio_in_i,
  input  logic [twspi_pkg::HalfW-1:0]      half_period_i,
  output twspi_pkg::result_t               result_o
);

  localparam int unsigned CntW = $clog2(MaxReadBytes + 1);
  localparam int unsigned CmpW = (CntW > twspi_pkg::ReadLenW) ? CntW : twspi_pkg::ReadLenW;
  localparam logic [CmpW-1:0] MaxExt = CmpW'(MaxReadBytes);

  localparam int unsigned ByteW = twspi_pkg::ByteW;
  localparam int unsigned HalfW = twspi_pkg::HalfW;
  localparam int unsigned BitW  = twspi_pkg::BitIdxW;

  twspi_pkg::phase_e   phase_q, phase_d;
  logic [HalfW-1:0]    tick_q, tick_d;
  logic [BitW-1:0]     bit_q, bit_d;
  logic [CntW-1:0]     left_q, left_d;
  logic [ByteW-1:0]    shift_out_q, shift_out_d;
  logic [ByteW-1:0]    shift_in_q, shift_in_d;
  logic [ByteW-1:0]    held_q, held_d;
  logic                is_read_q, is_read_d;
  logic                data_lvl_q, data_lvl_d;

  logic                start;
  logic                start_read;
  logic [CmpW-1:0]     len_ext;
  logic [CntW-1:0]     len_sat;
  logic [HalfW-1:0]    half_eff;
  logic                phase_end;
  logic [ByteW-1:0]    shift_in_nx;
  logic                cs, clk, data, drive;
  logic                valid, last;
  logic [ByteW-1:0]    rbyte;

  // burst length limited to the supported maximum
  assign len_ext = CmpW'(read_length_i);
  assign len_sat = (len_ext > MaxExt) ? CntW'(MaxExt) : CntW'(len_ext);

  // a zero half period behaves as one tick
  assign half_eff = (half_period_i == '0) ? HalfW'(1) : half_period_i;

  assign start      = (phase_q == twspi_pkg::PhIdle) &&
                      ((command_i == twspi_pkg::CmdWrite) || (command_i == twspi_pkg::CmdRead));
  assign start_read = (command_i == twspi_pkg::CmdRead);

  // frame sequencer: load on a command, then pins and phase advance
  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    left_d      = left_q;
    shift_out_d = shift_out_q;
    shift_in_d  = shift_in_q;
    held_d      = held_q;
    is_read_d   = is_read_q;

    if (start) begin
      is_read_d   = start_read;
      shift_out_d = {start_read, reg_addr_i};
      held_d      = write_value_i;
      left_d      = start_read ? len_sat : CntW'(1);
      bit_d       = '0;
      tick_d      = '0;
      shift_in_d  = '0;
      phase_d     = twspi_pkg::PhStartHi;
    end

    // pin levels of the current phase
    data  = data_lvl_q;
    cs    = 1'b0;
    clk   = 1'b1;
    drive = 1'b1;
    unique case (phase_d)
      twspi_pkg::PhStartHi: cs = 1'b1;
      twspi_pkg::PhStartLo: cs = 1'b0;
      twspi_pkg::PhTxLow: begin
        clk  = 1'b0;
        data = shift_out_d[~bit_d];
      end
      twspi_pkg::PhTxHigh: data = shift_out_d[~bit_d];
      twspi_pkg::PhRxLow: begin
        clk   = 1'b0;
        drive = 1'b0;
      end
      twspi_pkg::PhRxHigh: drive = 1'b0;
      twspi_pkg::PhFinClk: drive = ~is_read_d;
      twspi_pkg::PhFinCs: begin
        cs    = 1'b1;
        drive = ~is_read_d;
      end
      default: cs = 1'b1;
    endcase
    data_lvl_d = data;

    valid       = 1'b0;
    last        = 1'b0;
    rbyte       = '0;
    shift_in_nx = {shift_in_d[ByteW-2:0], sdio_in_i};
    phase_end   = ({1'b0, tick_d} + {{HalfW{1'b0}}, 1'b1}) >= {1'b0, half_eff};

    // phase advance once the half period has run out
    if (phase_d != twspi_pkg::PhIdle) begin
      if (phase_end) begin
        tick_d = '0;
        unique case (phase_d)
          twspi_pkg::PhStartHi: phase_d = twspi_pkg::PhStartLo;
          twspi_pkg::PhStartLo: phase_d = twspi_pkg::PhTxLow;
          twspi_pkg::PhTxLow:   phase_d = twspi_pkg::PhTxHigh;
          twspi_pkg::PhTxHigh: begin
            if (bit_d == '1) begin
              bit_d = '0;
              if (!is_read_d) begin
                if (left_d != '0) begin
                  left_d      = '0;
                  shift_out_d = held_d;
                  phase_d     = twspi_pkg::PhTxLow;
                end else begin
                  phase_d = twspi_pkg::PhFinClk;
                end
              end else begin
                phase_d = (left_d != '0) ? twspi_pkg::PhRxLow : twspi_pkg::PhFinClk;
              end
            end else begin
              bit_d   = bit_d + BitW'(1);
              phase_d = twspi_pkg::PhTxLow;
            end
          end
          twspi_pkg::PhRxLow: phase_d = twspi_pkg::PhRxHigh;
          twspi_pkg::PhRxHigh: begin
            shift_in_d = shift_in_nx;
            if (bit_d == '1) begin
              bit_d = '0;
              valid = 1'b1;
              rbyte = shift_in_nx;
              if (left_d != '0) begin
                left_d = left_d - CntW'(1);
              end
              last    = (left_d == '0);
              phase_d = last ? twspi_pkg::PhFinClk : twspi_pkg::PhRxLow;
            end else begin
              bit_d   = bit_d + BitW'(1);
              phase_d = twspi_pkg::PhRxLow;
            end
          end
          twspi_pkg::PhFinClk: phase_d = twspi_pkg::PhFinCs;
          default: begin
            phase_d   = twspi_pkg::PhIdle;
            is_read_d = 1'b0;
          end
        endcase
      end else begin
        tick_d = tick_d + HalfW'(1);
      end
    end

    result_o.chip_select_n = cs;
    result_o.serial_clock  = clk;
    result_o.data_out      = drive & data;
    result_o.data_drive    = drive;
    result_o.read_byte     = rbyte;
    result_o.byte_valid    = valid;
    result_o.last_byte     = last;
    result_o.busy_res      = (phase_q != twspi_pkg::PhIdle) || start;
  end

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= twspi_pkg::PhIdle;
      tick_q      <= '0;
      bit_q       <= '0;
      left_q      <= '0;
      shift_out_q <= '0;
      shift_in_q  <= '0;
      held_q      <= '0;
      is_read_q   <= 1'b0;
      data_lvl_q  <= 1'b1;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      left_q      <= left_d;
      shift_out_q <= shift_out_d;
      shift_in_q  <= shift_in_d;
      held_q      <= held_d;
      is_read_q   <= is_read_d;
      data_lvl_q  <= data_lvl_d;
    end
  end

endmodule

// ===== rtl/twspi_out_reg.sv =====
module twspi_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  twspi_pkg::result_t result_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output twspi_pkg::result_t result_o
);

  logic               valid_q;
  twspi_pkg::result_t data_q;

  // room when empty or the held result is taken this cycle
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= result_i;
    end
  end

endmodule

// ===== rtl/three_wire_spi_register_master.sv =====
// Three-wire SPI mode 3 register master, stepped by one input transfer per tick.
// Every accepted input transfer is one tick and yields exactly one output transfer
// carrying chip select, serial clock, data level and direction, plus any completed
// read byte with its last-byte flag. Command 1 runs a register write frame, command
// 2 a burst read of read_length bytes (capped at MaxReadBytes); commands are ignored while
// busy_res is high. Each clock half lasts half_period ticks (zero behaves as one); the user
// must write it through the configuration port only while idle; the block does not enforce it.
// Throughput is one tick per clock cycle; the result appears in the cycle after acceptance
// from the output register, and input is held off only while it is full and not taken.
module three_wire_spi_register_master #(
  parameter int unsigned MaxReadBytes = twspi_pkg::MaxReadBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [twspi_pkg::HalfW-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [twspi_pkg::CmdW-1:0]     command_i,
  input  logic [twspi_pkg::RegAddrW-1:0] reg_addr_i,
  input  logic [twspi_pkg::ByteW-1:0]    write_value_i,
  input  logic [twspi_pkg::ReadLenW-1:0] read_length_i,
  input  logic                           sdio_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           chip_select_n_o,
  output logic                           serial_clock_o,
  output logic                           data_out_o,
  output logic                           data_drive_o,
  output logic [twspi_pkg::ByteW-1:0]    read_byte_o,
  output logic                           byte_valid_o,
  output logic                           last_byte_o,
  output logic                           busy_res_o
);

  logic [twspi_pkg::HalfW-1:0] half_period_q;
  logic                        accept;
  twspi_pkg::result_t          seq_res;
  twspi_pkg::result_t          out_res;

  // half period register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= twspi_pkg::HalfPeriodReset;
    end else if (cfg_valid_i) begin
      half_period_q <= cfg_data_i;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  // frame sequencer
  twspi_seq #(
    .MaxReadBytes(MaxReadBytes)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (command_i),
    .reg_addr_i   (reg_addr_i),
    .write_value_i(write_value_i),
    .read_length_i(read_length_i),
    .sdio_in_i    (sdio_in_i),
    .half_period_i(half_period_q),
    .result_o     (seq_res)
  );

  // result register
  twspi_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .result_i   (seq_res),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (out_res)
  );

  assign chip_select_n_o = out_res.chip_select_n;
  assign serial_clock_o  = out_res.serial_clock;
  assign data_out_o      = out_res.data_out;
  assign data_drive_o    = out_res.data_drive;
  assign read_byte_o     = out_res.read_byte;
  assign byte_valid_o    = out_res.byte_valid;
  assign last_byte_o     = out_res.last_byte;
  assign busy_res_o      = out_res.busy_res;

endmodule

// ===== tb/sv/three_wire_spi_register_master_tb.sv =====
module three_wire_spi_register_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twspi_pkg::*;

  // expected pin levels per tick, from a local copy of the frame sequencer
  class spi_pin_scoreboard;
    logic [HalfW-1:0]    half_period;
    phase_e              seq_phase;
    logic [7:0]          tick_count;
    logic [BitIdxW-1:0]  bit_index;
    logic [ReadLenW-1:0] bytes_left;
    logic [ByteW-1:0]    shift_out;
    logic [ByteW-1:0]    shift_in;
    logic [ByteW-1:0]    held_value;
    logic                is_read;
    logic                data_level;
    result_t             expected_pins[$];
    int unsigned         checked_no;
    int unsigned         mismatch_count;

    function new();
      half_period    = HalfPeriodReset;
      seq_phase      = PhIdle;
      tick_count     = '0;
      bit_index      = '0;
      bytes_left     = '0;
      shift_out      = '0;
      shift_in       = '0;
      held_value     = '0;
      is_read        = 1'b0;
      data_level     = 1'b1;
      checked_no     = 0;
      mismatch_count = 0;
    endfunction

    function void set_half_period(logic [HalfW-1:0] value);
      half_period = value;
    endfunction

    function bit seq_idle();
      return seq_phase == PhIdle;
    endfunction

    function int unsigned pending();
      return expected_pins.size();
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    // advance the sequencer by one accepted tick and queue its pin levels
    function void note_tick(logic [CmdW-1:0] cmd, logic [RegAddrW-1:0] reg_addr,
                            logic [ByteW-1:0] wval, logic [ReadLenW-1:0] len,
                            logic sdi);
      int unsigned hp;
      logic        cs;
      logic        sclk;
      logic        data;
      logic        drive;
      result_t     res;
      hp  = (half_period == '0) ? 1 : int'(half_period);
      res = '0;

      // a command seen while idle opens the frame on this same tick
      if (seq_phase == PhIdle && (cmd == CmdWrite || cmd == CmdRead)) begin
        is_read    = (cmd == CmdRead);
        shift_out  = {is_read, reg_addr};
        held_value = wval;
        if (!is_read) begin
          bytes_left = 5'd1;
        end else if (int'(len) > MaxReadBytesDefault) begin
          bytes_left = ReadLenW'(MaxReadBytesDefault);
        end else begin
          bytes_left = len;
        end
        bit_index  = '0;
        tick_count = '0;
        shift_in   = '0;
        seq_phase  = PhStartHi;
      end

      // pin levels for the current phase
      data  = data_level;
      cs    = 1'b0;
      sclk  = 1'b1;
      drive = 1'b1;
      case (seq_phase)
        PhStartHi: cs = 1'b1;
        PhStartLo: ;
        PhTxLow, PhTxHigh: begin
          sclk = (seq_phase == PhTxHigh);
          data = shift_out[3'd7 - bit_index];
        end
        PhRxLow: begin
          sclk  = 1'b0;
          drive = 1'b0;
        end
        PhRxHigh: drive = 1'b0;
        PhFinClk: drive = !is_read;
        PhFinCs: begin
          cs    = 1'b1;
          drive = !is_read;
        end
        default: cs = 1'b1;
      endcase
      data_level = data;

      // phase timing and bit sequencing
      if (seq_phase != PhIdle) begin
        res.busy_res = 1'b1;
        if (int'(tick_count) + 1 >= hp) begin
          tick_count = '0;
          case (seq_phase)
            PhStartHi: seq_phase = PhStartLo;
            PhStartLo: seq_phase = PhTxLow;
            PhTxLow:   seq_phase = PhTxHigh;
            PhTxHigh: begin
              if (bit_index == 3'd7) begin
                bit_index = '0;
                if (!is_read) begin
                  if (bytes_left != '0) begin
                    bytes_left = '0;
                    shift_out  = held_value;
                    seq_phase  = PhTxLow;
                  end else begin
                    seq_phase = PhFinClk;
                  end
                end else begin
                  seq_phase = (bytes_left != '0) ? PhRxLow : PhFinClk;
                end
              end else begin
                bit_index++;
                seq_phase = PhTxLow;
              end
            end
            PhRxLow: seq_phase = PhRxHigh;
            PhRxHigh: begin
              shift_in = {shift_in[6:0], sdi};
              if (bit_index == 3'd7) begin
                bit_index      = '0;
                res.byte_valid = 1'b1;
                res.read_byte  = shift_in;
                if (bytes_left != '0) bytes_left--;
                res.last_byte  = (bytes_left == '0);
                seq_phase      = res.last_byte ? PhFinClk : PhRxLow;
              end else begin
                bit_index++;
                seq_phase = PhRxLow;
              end
            end
            PhFinClk: seq_phase = PhFinCs;
            default: begin
              seq_phase = PhIdle;
              is_read   = 1'b0;
            end
          endcase
        end else begin
          tick_count++;
        end
      end

      res.chip_select_n = cs;
      res.serial_clock  = sclk;
      res.data_out      = drive ? data : 1'b0;
      res.data_drive    = drive;
      expected_pins.push_back(res);
    endfunction

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                  checked_no, name, got, want));
      end
    endtask

    // compare one output transfer with the oldest expectation
    task check_pins(result_t got);
      result_t want;
      if (expected_pins.size() == 0) begin
        report_mismatch("output transfer with no tick outstanding");
        return;
      end
      want = expected_pins.pop_front();
      compare_field("chip_select_n", got.chip_select_n, want.chip_select_n);
      compare_field("serial_clock", got.serial_clock, want.serial_clock);
      compare_field("data_out", got.data_out, want.data_out);
      compare_field("data_drive", got.data_drive, want.data_drive);
      compare_field("read_byte", got.read_byte, want.read_byte);
      compare_field("byte_valid", got.byte_valid, want.byte_valid);
      compare_field("last_byte", got.last_byte, want.last_byte);
      compare_field("busy_res", got.busy_res, want.busy_res);
      checked_no++;
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [HalfW-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CmdW-1:0]     command_i;
  logic [RegAddrW-1:0] reg_addr_i;
  logic [ByteW-1:0]    write_value_i;
  logic [ReadLenW-1:0] read_length_i;
  logic                sdio_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                chip_select_n_o;
  logic                serial_clock_o;
  logic                data_out_o;
  logic                data_drive_o;
  logic [ByteW-1:0]    read_byte_o;
  logic                byte_valid_o;
  logic                last_byte_o;
  logic                busy_res_o;

  spi_pin_scoreboard sb = new();
  bit                long_hold_req = 1'b0;
  bit                calm = 1'b0;

  three_wire_spi_register_master uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .reg_addr_i     (reg_addr_i),
    .write_value_i  (write_value_i),
    .read_length_i  (read_length_i),
    .sdio_in_i      (sdio_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chip_select_n_o(chip_select_n_o),
    .serial_clock_o (serial_clock_o),
    .data_out_o     (data_out_o),
    .data_drive_o   (data_drive_o),
    .read_byte_o    (read_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_byte_o    (last_byte_o),
    .busy_res_o     (busy_res_o)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // read lengths: mostly short, some zero, some beyond the burst limit
  function automatic logic [ReadLenW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 60) return ReadLenW'($urandom_range(1, 2));
    if (r < 80) return ReadLenW'($urandom_range(3, 4));
    if (r < 90) return ReadLenW'($urandom_range(5, 15));
    return ReadLenW'($urandom_range(16, 31));
  endfunction

  // one input transfer, then an optional gap
  task automatic send_tick(logic [CmdW-1:0] cmd, logic [RegAddrW-1:0] ra,
                           logic [ByteW-1:0] wv, logic [ReadLenW-1:0] rl,
                           int unsigned gap);
    logic sdi;
    sdi = 1'($urandom_range(0, 1));
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    reg_addr_i    <= ra;
    write_value_i <= wv;
    read_length_i <= rl;
    sdio_in_i     <= sdi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_tick(cmd, ra, wv, rl, sdi);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // tick during a frame, now and then carrying a command that must be ignored
  task automatic send_filler(int unsigned gap);
    logic [CmdW-1:0] cmd;
    cmd = ($urandom_range(0, 99) < 12) ? CmdW'($urandom_range(0, 3)) : CmdTick;
    send_tick(cmd, RegAddrW'($urandom), ByteW'($urandom), ReadLenW'($urandom), gap);
  endtask

  task automatic run_to_idle();
    while (!sb.seq_idle()) send_filler(pick_gap());
  endtask

  // stop offering and wait until every result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_half_period(logic [HalfW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_half_period(value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random tick: frames started while idle, noise while busy
  task automatic random_item(int unsigned gap);
    int unsigned r;
    if (!sb.seq_idle()) begin
      send_filler(gap);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_tick($urandom_range(0, 1) ? CmdWrite : CmdRead, RegAddrW'($urandom),
                  ByteW'($urandom), pick_len(), gap);
      end else if (r < 50) begin
        send_tick(CmdW'(3), RegAddrW'($urandom), ByteW'($urandom), pick_len(), gap);
      end else begin
        send_tick(CmdTick, RegAddrW'($urandom), ByteW'($urandom), pick_len(), gap);
      end
    end
  endtask

  // output side: check each transfer, then choose ready for the next cycle
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned r;
    result_t     got;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        got = {chip_select_n_o, serial_clock_o, data_out_o, data_drive_o,
               read_byte_o, byte_valid_o, last_byte_o, busy_res_o};
        sb.check_pins(got);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = 80;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 30);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [HalfW-1:0] hp_list[5];
    int unsigned      wait_cycles;
    hp_list = '{8'd1, 8'd0, 8'd2, 8'd1, 8'd3};
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    command_i     <= CmdTick;
    reg_addr_i    <= '0;
    write_value_i <= '0;
    read_length_i <= '0;
    sdio_in_i     <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // write with all ones at the reset half period, a read arriving while busy
    send_tick(CmdWrite, 7'h7F, 8'hFF, 5'd0, pick_gap());
    send_tick(CmdRead, 7'h00, 8'h00, 5'd3, pick_gap());
    run_to_idle();

    // zero half period acts as one, write with all zeros
    drain();
    write_half_period(8'd0);
    send_tick(CmdWrite, 7'h00, 8'h00, 5'd31, pick_gap());
    run_to_idle();

    // single byte read, zero length read, saturating burst
    drain();
    write_half_period(8'd1);
    send_tick(CmdRead, 7'h7F, 8'hFF, 5'd1, pick_gap());
    run_to_idle();
    send_tick(CmdRead, 7'h00, 8'h00, 5'd0, pick_gap());
    run_to_idle();
    send_tick(CmdRead, 7'h55, 8'h5A, 5'd31, pick_gap());
    run_to_idle();

    // unused command code is a plain tick
    send_tick(CmdW'(3), 7'h7F, 8'hFF, 5'd31, pick_gap());
    send_tick(CmdTick, 7'h7F, 8'hFF, 5'd31, pick_gap());

    // half period changed mid frame: up to the maximum, then back below the count
    drain();
    write_half_period(8'd2);
    send_tick(CmdWrite, 7'h55, 8'hA5, 5'd1, pick_gap());
    repeat (6) send_filler(pick_gap());
    drain();
    write_half_period(8'd255);
    repeat (20) send_filler(pick_gap());
    drain();
    write_half_period(8'd2);
    run_to_idle();

    // random phases, each with a half period taken in turn from hp_list
    for (int p = 0; p < 5; p++) begin
      drain();
      write_half_period(hp_list[p]);
      calm = (p == 3);
      for (int i = 0; i < 20; i++) begin
        // long receiver hold-off while the sender keeps offering
        if (p == 1 && i == 4) long_hold_req = 1'b1;
        // sender pause until everything has come back
        if (p == 2 && i == 10) drain();
        random_item((calm || (p == 1 && i >= 4 && i < 16)) ? 0 : pick_gap());
      end
    end
    calm = 1'b0;

    // wind down
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    end
    if (sb.mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
